// File: hdl/pressure_temperature_compensation_assert.svh
// Assertion macros for the pressure and temperature compensation checker.
// Used by the checker file only; needs clk and rst_n in scope.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define PTC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc assertion failed");
// Next-cycle implication, disabled during reset.
`define PTC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc assertion failed");
`endif

// File: hdl/ptc_pkg.sv
// Package for the pressure and temperature compensation block.
// Holds register indexes, widths and shared constants; no dependencies.
package ptc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_WORDS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_A = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_B = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_NINE = 3'd3;
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] P1_BIAS = 64'h0000_8000_0000_0000;
  localparam logic [63:0] RAW_FULL = 64'd1048576;
  localparam logic [63:0] DIV_SCALE = 64'd3125;

  function automatic logic [63:0] sx16(input logic [15:0] w);
    sx16 = {{48{w[15]}}, w};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] w);
    sx32 = {{32{w[31]}}, w};
  endfunction
endpackage

// File: hdl/pressure_temperature_compensation.sv
// Top level of the pressure and temperature compensation block.
// Uses ptc_pkg; one shift-add multiplier and one restoring divider, one bit per cycle.
// Temperature uses three multiplies; pressure uses up to ten multiplies and a divide.
// One item at a time; the next is accepted in the cycle after the result loads.
// Reset (rst_n low, synchronous) clears calibration, fine temperature and control.
module pressure_temperature_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [19:0]                 in_raw_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_result_kind,
  output logic signed [31:0]          out_temperature_centi,
  output logic [31:0]                 out_pressure_q24_8,
  output logic                        out_divide_fault,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                 cfg_wdata
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MUL  = 5'd1;
  localparam logic [4:0] S_TA   = 5'd2;
  localparam logic [4:0] S_TB   = 5'd3;
  localparam logic [4:0] S_TC   = 5'd4;
  localparam logic [4:0] S_TD   = 5'd5;
  localparam logic [4:0] S_PA   = 5'd6;
  localparam logic [4:0] S_PB   = 5'd7;
  localparam logic [4:0] S_PC   = 5'd8;
  localparam logic [4:0] S_PD   = 5'd9;
  localparam logic [4:0] S_PE   = 5'd10;
  localparam logic [4:0] S_PF   = 5'd11;
  localparam logic [4:0] S_PG   = 5'd12;
  localparam logic [4:0] S_PH   = 5'd13;
  localparam logic [4:0] S_DIV  = 5'd14;
  localparam logic [4:0] S_PI   = 5'd15;
  localparam logic [4:0] S_PJ   = 5'd16;
  localparam logic [4:0] S_PK   = 5'd17;
  localparam logic [4:0] S_PL   = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;

  logic [47:0] cal_t_r;
  logic [63:0] cal_pa_r, cal_pb_r;
  logic [15:0] cal_p9_r;
  logic [31:0] fine_r, fine_nxt;
  logic [4:0]  state_r, state_nxt, ret_r, ret_nxt;
  logic        kind_r, kind_nxt;
  logic [19:0] adc_r, adc_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt, acc_r, acc_nxt;
  logic [63:0] x1_r, x1_nxt, x2_r, x2_nxt, s_r, s_nxt, q_r, q_nxt;
  logic [63:0] dvd_r, dvd_nxt, dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rt_r, rt_nxt, rp_r, rp_nxt;
  logic        rf_r, rf_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        okind_r, okind_nxt, ofault_r, ofault_nxt;
  logic [31:0] otemp_r, otemp_nxt, opress_r, opress_nxt;

  logic [31:0] t_a, t_d, acc32, fine_c, t5;
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] v1c, sum_f, dvc, pv, qc, rsum;
  logic [64:0] rem_sh;

  assign t1 = {48'd0, cal_t_r[15:0]};
  assign t2 = ptc_pkg::sx16(cal_t_r[31:16]);
  assign t3 = ptc_pkg::sx16(cal_t_r[47:32]);
  assign p1 = {48'd0, cal_pa_r[15:0]};
  assign p2 = ptc_pkg::sx16(cal_pa_r[31:16]);
  assign p3 = ptc_pkg::sx16(cal_pa_r[47:32]);
  assign p4 = ptc_pkg::sx16(cal_pa_r[63:48]);
  assign p5 = ptc_pkg::sx16(cal_pb_r[15:0]);
  assign p6 = ptc_pkg::sx16(cal_pb_r[31:16]);
  assign p7 = ptc_pkg::sx16(cal_pb_r[47:32]);
  assign p8 = ptc_pkg::sx16(cal_pb_r[63:48]);
  assign p9 = ptc_pkg::sx16(cal_p9_r);

  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_result_kind = okind_r;
  assign out_temperature_centi = otemp_r;
  assign out_pressure_q24_8 = opress_r;
  assign out_divide_fault = ofault_r;

  always_comb begin
    t_a = {15'd0, adc_r[19:3]} - {t1[30:0], 1'b0};
    t_d = {16'd0, adc_r[19:4]} - t1[31:0];
    acc32 = acc_r[31:0];
    fine_c = x1_r[31:0] + 32'($signed(acc32) >>> 14);
    t5 = {fine_c[29:0], 2'b00} + fine_c + 32'd128;
    v1c = ptc_pkg::sx32(fine_r) - ptc_pkg::FINE_OFFSET;
    sum_f = s_r + {acc_r[51:0], 12'd0};
    dvc = 64'($signed(acc_r) >>> 33);
    pv = ptc_pkg::RAW_FULL - {44'd0, adc_r};
    rem_sh = {rem_r, dvd_r[63]};
    qc = neg_r ? (64'd0 - dvd_r) : dvd_r;
    rsum = q_r + x1_r + 64'($signed(acc_r) >>> 19);
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    kind_nxt = kind_r;
    adc_nxt = adc_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    s_nxt = s_r;
    q_nxt = q_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    fine_nxt = fine_r;
    rt_nxt = rt_r;
    rp_nxt = rp_r;
    rf_nxt = rf_r;
    out_valid_nxt = out_valid_r && out_stall;
    okind_nxt = okind_r;
    otemp_nxt = otemp_r;
    opress_nxt = opress_r;
    ofault_nxt = ofault_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_req_type;
          adc_nxt = in_raw_sample;
          state_nxt = in_req_type ? S_PA : S_TA;
        end
      end
      S_MUL: begin
        if (mb_r == 64'd0) begin
          state_nxt = ret_r;
        end else begin
          if (mb_r[0]) acc_nxt = acc_r + ma_r;
          ma_nxt = {ma_r[62:0], 1'b0};
          mb_nxt = {1'b0, mb_r[63:1]};
        end
      end
      S_TA: begin
        ma_nxt = ptc_pkg::sx32(t_a);
        mb_nxt = t2;
        acc_nxt = '0;
        ret_nxt = S_TB;
        state_nxt = S_MUL;
      end
      S_TB: begin
        x1_nxt = ptc_pkg::sx32(32'($signed(acc32) >>> 11));
        ma_nxt = ptc_pkg::sx32(t_d);
        mb_nxt = ptc_pkg::sx32(t_d);
        acc_nxt = '0;
        ret_nxt = S_TC;
        state_nxt = S_MUL;
      end
      S_TC: begin
        ma_nxt = ptc_pkg::sx32(32'($signed(acc32) >>> 12));
        mb_nxt = t3;
        acc_nxt = '0;
        ret_nxt = S_TD;
        state_nxt = S_MUL;
      end
      S_TD: begin
        fine_nxt = fine_c;
        rt_nxt = 32'($signed(t5) >>> 8);
        rp_nxt = '0;
        rf_nxt = 1'b0;
        state_nxt = S_FIN;
      end
      S_PA: begin
        x1_nxt = v1c;
        ma_nxt = v1c;
        mb_nxt = v1c;
        acc_nxt = '0;
        ret_nxt = S_PB;
        state_nxt = S_MUL;
      end
      S_PB: begin
        s_nxt = acc_r;
        ma_nxt = acc_r;
        mb_nxt = p6;
        acc_nxt = '0;
        ret_nxt = S_PC;
        state_nxt = S_MUL;
      end
      S_PC: begin
        x2_nxt = acc_r;
        ma_nxt = x1_r;
        mb_nxt = p5;
        acc_nxt = '0;
        ret_nxt = S_PD;
        state_nxt = S_MUL;
      end
      S_PD: begin
        x2_nxt = x2_r + {acc_r[46:0], 17'd0} + {p4[28:0], 35'd0};
        ma_nxt = s_r;
        mb_nxt = p3;
        acc_nxt = '0;
        ret_nxt = S_PE;
        state_nxt = S_MUL;
      end
      S_PE: begin
        s_nxt = 64'($signed(acc_r) >>> 8);
        ma_nxt = x1_r;
        mb_nxt = p2;
        acc_nxt = '0;
        ret_nxt = S_PF;
        state_nxt = S_MUL;
      end
      S_PF: begin
        ma_nxt = ptc_pkg::P1_BIAS + sum_f;
        mb_nxt = p1;
        acc_nxt = '0;
        ret_nxt = S_PG;
        state_nxt = S_MUL;
      end
      S_PG: begin
        if (dvc == 64'd0) begin
          rt_nxt = '0;
          rp_nxt = '0;
          rf_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          x1_nxt = dvc;
          ma_nxt = {pv[32:0], 31'd0} - x2_r;
          mb_nxt = ptc_pkg::DIV_SCALE;
          acc_nxt = '0;
          ret_nxt = S_PH;
          state_nxt = S_MUL;
        end
      end
      S_PH: begin
        neg_nxt = acc_r[63] ^ x1_r[63];
        dvd_nxt = acc_r[63] ? (64'd0 - acc_r) : acc_r;
        dvs_nxt = x1_r[63] ? (64'd0 - x1_r) : x1_r;
        rem_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_nxt = 64'(rem_sh - {1'b0, dvs_r});
          dvd_nxt = {dvd_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          dvd_nxt = {dvd_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_PI;
      end
      S_PI: begin
        q_nxt = qc;
        ma_nxt = 64'($signed(qc) >>> 13);
        mb_nxt = 64'($signed(qc) >>> 13);
        acc_nxt = '0;
        ret_nxt = S_PJ;
        state_nxt = S_MUL;
      end
      S_PJ: begin
        ma_nxt = acc_r;
        mb_nxt = p9;
        acc_nxt = '0;
        ret_nxt = S_PK;
        state_nxt = S_MUL;
      end
      S_PK: begin
        x1_nxt = 64'($signed(acc_r) >>> 25);
        ma_nxt = q_r;
        mb_nxt = p8;
        acc_nxt = '0;
        ret_nxt = S_PL;
        state_nxt = S_MUL;
      end
      S_PL: begin
        rt_nxt = '0;
        rp_nxt = 32'($signed(rsum) >>> 8) + {p7[27:0], 4'd0};
        rf_nxt = 1'b0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          okind_nxt = kind_r;
          otemp_nxt = rt_r;
          opress_nxt = rp_r;
          ofault_nxt = rf_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      out_valid_r <= 1'b0;
      fine_r <= '0;
      cal_t_r <= '0;
      cal_pa_r <= '0;
      cal_pb_r <= '0;
      cal_p9_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      fine_r <= fine_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          ptc_pkg::CFG_TEMP_WORDS: cal_t_r <= cfg_wdata[47:0];
          ptc_pkg::CFG_PRESS_A:    cal_pa_r <= cfg_wdata;
          ptc_pkg::CFG_PRESS_B:    cal_pb_r <= cfg_wdata;
          ptc_pkg::CFG_PRESS_NINE: cal_p9_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    adc_r <= adc_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    acc_r <= acc_nxt;
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    s_r <= s_nxt;
    q_r <= q_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rt_r <= rt_nxt;
    rp_r <= rp_nxt;
    rf_r <= rf_nxt;
    okind_r <= okind_nxt;
    otemp_r <= otemp_nxt;
    opress_r <= opress_nxt;
    ofault_r <= ofault_nxt;
  end
endmodule

// File: hdl/ptc_checker.sv
// Port-level checker for the pressure and temperature compensation block.
// Uses the assertion macros header; bound to the top level below.
`include "pressure_temperature_compensation_assert.svh"
module ptc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [31:0] out_temperature_centi,
  input logic [31:0] out_pressure_q24_8,
  input logic        out_divide_fault
);
  `PTC_ASSERT_IMP(temp_item_clean, out_valid && !out_result_kind, out_pressure_q24_8 == 32'd0 && !out_divide_fault)
  `PTC_ASSERT_IMP(press_item_clean, out_valid && out_result_kind, out_temperature_centi == 32'd0)
  `PTC_ASSERT_IMP(fault_zero, out_valid && out_divide_fault, out_pressure_q24_8 == 32'd0)
  `PTC_ASSERT_NXT(accept_busy, in_valid && !in_stall, in_stall)
endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_result_kind(out_result_kind),
  .out_temperature_centi(out_temperature_centi),
  .out_pressure_q24_8(out_pressure_q24_8),
  .out_divide_fault(out_divide_fault)
);
